[design/device_table_evict_oldest_assert.svh]
// assertion macros shared by the table design
`ifndef DEVICE_TABLE_EVICT_OLDEST_ASSERT_SVH
`define DEVICE_TABLE_EVICT_OLDEST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DTEO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dteo assertion failed");

// next-cycle implication, checked out of reset
`define DTEO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dteo assertion failed");

`endif

[design/dteo_pkg.sv]
`timescale 1ns / 1ps
package dteo_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned KW = $clog2(TableDepth + 2);
  // scan index must also hold start_index + 1
  localparam int unsigned ScanW = (CntW > 9) ? CntW : 9;

  localparam logic [1:0] FuncAppend = 2'd0;
  localparam logic [1:0] FuncDelete = 2'd1;
  localparam logic [1:0] FuncFind   = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  localparam logic signed [7:0] PosNone = -8'sd1;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] device_id;
    logic [47:0]        bt_address;
    logic [63:0]        last_used_time;
    logic [63:0]        current_time;
    logic               mark_used;
    logic signed [7:0]  start_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [7:0]  position;
    logic signed [31:0] assigned_id;
    logic               evicted;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic        used;
    logic [63:0] ltime;
  } entry_t;

  typedef struct packed {
    logic            en_all;
    logic            en_used;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } wr_req_t;

endpackage

[design/dteo_store.sv]
`timescale 1ns / 1ps
module dteo_store (
  input  logic                   clk_i,
  input  dteo_pkg::wr_req_t      wr_i,
  input  logic [dteo_pkg::IdxW-1:0] rd_addr_i,
  output dteo_pkg::entry_t       rd_o
);
  import dteo_pkg::*;

  logic [31:0] ids_mem   [TableDepth];
  logic        used_mem  [TableDepth];
  logic [63:0] times_mem [TableDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en_all) begin
      ids_mem[wr_i.addr]   <= wr_i.data.id;
      times_mem[wr_i.addr] <= wr_i.data.ltime;
    end
    if (wr_i.en_all || wr_i.en_used) begin
      used_mem[wr_i.addr] <= wr_i.data.used;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_o.id    <= ids_mem[rd_addr_i];
    rd_o.used  <= used_mem[rd_addr_i];
    rd_o.ltime <= times_mem[rd_addr_i];
  end

endmodule

[design/device_table_evict_oldest.sv]
`timescale 1ns / 1ps
// Device table of 128 entries (id, used mark, last-used time) handling append, delete and
// find one request at a time through a table memory with one read and one write port.
// Each entry visited takes a read step, then a compare or write step. An append with
// a given id writes the entry directly; an assigned id is probed against the table,
// bumping and rescanning up to 129 passes when many ids collide. An append to a full
// table first scans for the oldest unused entry as victim and shifts the entries after
// it down. A result may wait in the output register while the next request is taken.
module device_table_evict_oldest (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dteo_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dteo_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [30:0]          cfg_data_i
);
  import dteo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_VRD, S_VCMP, S_SRD, S_SWR, S_IDGEN, S_PRD, S_PCMP,
    S_AWR, S_FRD, S_FCMP, S_FIN
  } state_e;

  state_e          state_q;
  logic [ScanW-1:0] idx_q;
  logic [CntW-1:0] cnt_q;
  logic [KW-1:0]   k_q;
  in_item_t        req_q;
  logic [31:0]     id_q;
  logic [63:0]     oldest_q;
  logic            found_q;
  logic [IdxW-1:0] victim_q;
  logic            ev_q;
  logic [30:0]     mask_q;
  out_item_t       res_q;
  out_item_t       out_q;
  logic            out_valid_q;

  wr_req_t         wr;
  entry_t          rd;
  logic [ScanW-1:0] nxt;
  logic [ScanW-1:0] cnt_ext;
  logic [ScanW-1:0] from;
  logic [IdxW-1:0] rd_addr;

  assign nxt     = idx_q + ScanW'(1);
  assign cnt_ext = ScanW'(cnt_q);
  assign rd_addr = (state_q == S_SRD) ? nxt[IdxW-1:0] : idx_q[IdxW-1:0];

  // find starts after start_index; anything below -1 searches from 0
  always_comb begin
    from = '0;
    if (in_data_i.func == FuncFind && in_data_i.start_index >= -8'sd1) begin
      from = ScanW'({in_data_i.start_index[7], in_data_i.start_index} + 9'd1);
    end
  end

  always_comb begin
    wr = '0;
    wr.addr = idx_q[IdxW-1:0];
    wr.data = rd;
    case (state_q)
      S_SWR: wr.en_all = 1'b1;
      S_AWR: begin
        wr.en_all = 1'b1;
        wr.addr = cnt_q[IdxW-1:0];
        wr.data.id = id_q;
        wr.data.used = req_q.mark_used;
        wr.data.ltime = req_q.last_used_time;
      end
      S_FCMP: begin
        wr.en_used = (req_q.func == FuncDelete) && (rd.id == req_q.device_id);
        wr.data.used = 1'b0;
      end
      default: ;
    endcase
  end

  dteo_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      req_q       <= '0;
      id_q        <= '0;
      oldest_q    <= '0;
      found_q     <= 1'b0;
      victim_q    <= '0;
      ev_q        <= 1'b0;
      mask_q      <= 31'h7FFF_FFFF;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            ev_q  <= 1'b0;
            case (in_data_i.func)
              FuncAppend: begin
                if (cnt_q == CntW'(TableDepth)) begin
                  idx_q    <= '0;
                  oldest_q <= in_data_i.current_time;
                  found_q  <= 1'b0;
                  victim_q <= '0;
                  state_q  <= S_VRD;
                end else begin
                  state_q <= S_IDGEN;
                end
              end
              FuncDelete, FuncFind: begin
                idx_q   <= (from > cnt_ext) ? cnt_ext : from;
                state_q <= S_FRD;
              end
              default: begin
                res_q   <= '{StatusNotFound, PosNone, in_data_i.device_id, 1'b0};
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_VRD: begin
          if (idx_q < cnt_ext) begin
            state_q <= S_VCMP;
          end else if (!found_q) begin
            res_q   <= '{StatusFull, PosNone, req_q.device_id, 1'b0};
            state_q <= S_FIN;
          end else begin
            idx_q   <= ScanW'(victim_q);
            state_q <= S_SRD;
          end
        end
        S_VCMP: begin
          if (!rd.used && rd.ltime < oldest_q) begin
            oldest_q <= rd.ltime;
            victim_q <= idx_q[IdxW-1:0];
            found_q  <= 1'b1;
          end
          idx_q   <= nxt;
          state_q <= S_VRD;
        end
        S_SRD: begin
          if (nxt < cnt_ext) begin
            state_q <= S_SWR;
          end else begin
            cnt_q   <= cnt_q - CntW'(1);
            ev_q    <= 1'b1;
            state_q <= S_IDGEN;
          end
        end
        S_SWR: begin
          idx_q   <= nxt;
          state_q <= S_SRD;
        end
        S_IDGEN: begin
          if (req_q.device_id == 32'sd0 || req_q.device_id[31]) begin
            id_q    <= req_q.bt_address[31:0] & {1'b0, mask_q};
            k_q     <= '0;
            idx_q   <= '0;
            state_q <= S_PRD;
          end else begin
            id_q    <= req_q.device_id;
            state_q <= S_AWR;
          end
        end
        S_PRD: begin
          state_q <= (idx_q < cnt_ext) ? S_PCMP : S_AWR;
        end
        S_PCMP: begin
          if (rd.id == id_q) begin
            // taken: bump the id and rescan, bounded by depth + 1 bumps
            id_q  <= id_q + 32'd1;
            k_q   <= k_q + KW'(1);
            idx_q <= '0;
            state_q <= (k_q == KW'(TableDepth)) ? S_AWR : S_PRD;
          end else begin
            idx_q   <= nxt;
            state_q <= S_PRD;
          end
        end
        S_AWR: begin
          cnt_q   <= cnt_q + CntW'(1);
          res_q   <= '{StatusOk, 8'(cnt_q), id_q, ev_q};
          state_q <= S_FIN;
        end
        S_FRD: begin
          if (idx_q < cnt_ext) begin
            state_q <= S_FCMP;
          end else begin
            res_q   <= '{StatusNotFound, PosNone, req_q.device_id, 1'b0};
            state_q <= S_FIN;
          end
        end
        S_FCMP: begin
          if (rd.id == req_q.device_id) begin
            res_q   <= '{StatusOk, 8'(idx_q), req_q.device_id, 1'b0};
            state_q <= S_FIN;
          end else begin
            idx_q   <= nxt;
            state_q <= S_FRD;
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`include "device_table_evict_oldest_assert.svh"

  `DTEO_ASSERT_NXT(a_busy_after_req, in_valid_i && !in_stall_o, state_q != S_IDLE)
  `DTEO_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(TableDepth))
  `DTEO_ASSERT_NXT(a_cnt_only_on_update, state_q != S_AWR && state_q != S_SRD, $stable(cnt_q))
  `DTEO_ASSERT_IMP(a_out_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN)

endmodule
